FILE: rtl/core/hsfd_pkg.sv
// Package with shared types, constants and helper functions of the sensor frame decoder.
`default_nettype none

package hsfd_pkg;

  localparam int unsigned QUEUE_DEPTH = 2;

  localparam logic [7:0]  CRC_INIT   = 8'hFF;
  localparam logic [7:0]  CRC_POLY   = 8'h31;

  localparam int unsigned TEMP_SCALE  = 17500;
  localparam int unsigned TEMP_OFFSET = 4500;
  localparam int unsigned HUM_SCALE   = 12500;
  localparam int unsigned HUM_OFFSET  = 600;
  localparam int unsigned HUM_MAX     = 10000;
  localparam int unsigned FULL_SCALE  = 65535;

  typedef enum logic [1:0] {
    STATUS_OK          = 2'd0,
    STATUS_CRC_ERR     = 2'd1,
    STATUS_ZERO_SERIAL = 2'd2
  } status_e;

  typedef enum logic [2:0] {
    POS_FIRST_HI  = 3'd0,
    POS_FIRST_LO  = 3'd1,
    POS_FIRST_CRC = 3'd2,
    POS_SECOND_HI = 3'd3,
    POS_SECOND_LO = 3'd4,
    POS_LAST_CRC  = 3'd5
  } byte_pos_e;

  // One complete frame as handed from the front to the back.
  typedef struct packed {
    logic        serial_kind;
    logic        crc_ok;
    logic [15:0] first_word;
    logic [15:0] second_word;
  } frame_t;

  // Queue handshake toward the back.
  typedef struct packed {
    logic   empty;
    frame_t head;
  } queue_rd_t;

  // Feeds one byte into the CRC-8, MSB first, no reflection.
  function automatic logic [7:0] crc_feed(input logic [7:0] crc, input logic [7:0] b);
    logic [7:0] c;
    c = crc ^ b;
    for (int i = 0; i < 8; i++) begin
      if (c[7]) begin
        c = {c[6:0], 1'b0} ^ CRC_POLY;
      end else begin
        c = {c[6:0], 1'b0};
      end
    end
    return c;
  endfunction

  // Floor of x / 65535 for x below 2^31: the estimate x >> 16 is low by at most one.
  function automatic logic [14:0] div_full_scale(input logic [30:0] x);
    logic [14:0] q0;
    logic [16:0] r0;
    q0 = x[30:16];
    r0 = 17'(x[15:0]) + 17'(q0);
    if (r0 >= 17'(FULL_SCALE)) begin
      return q0 + 15'd1;
    end
    return q0;
  endfunction

endpackage

`default_nettype wire

FILE: rtl/core/hsfd_if.sv
// Channel interfaces of the sensor frame decoder: configuration, byte input and result output.
`default_nettype none

interface hsfd_cfg_if;
  logic valid;
  logic ready;
  logic frame_kind;

  modport source (output valid, output frame_kind, input ready);
  modport sink (input valid, input frame_kind, output ready);
endinterface

interface hsfd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;
  logic       frame_start;

  modport source (output valid, output rx_byte, output frame_start, input ready);
  modport sink (input valid, input rx_byte, input frame_start, output ready);
endinterface

interface hsfd_out_if;
  logic               valid;
  logic               ready;
  logic [1:0]         status;
  logic [15:0]        raw_first_word;
  logic [15:0]        raw_second_word;
  logic signed [14:0] temperature_centi;
  logic [13:0]        humidity_centi;
  logic [31:0]        serial_id;

  modport source (output valid, output status, output raw_first_word,
                  output raw_second_word, output temperature_centi,
                  output humidity_centi, output serial_id, input ready);
  modport sink (input valid, input status, input raw_first_word,
                input raw_second_word, input temperature_centi,
                input humidity_centi, input serial_id, output ready);
endinterface

`default_nettype wire

FILE: rtl/core/hsfd_front.sv
// Front end: accepts bytes, runs the CRC, assembles the words and queues complete frames.
`default_nettype none

module hsfd_front (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  hsfd_cfg_if.sink             cfg_i,
  hsfd_in_if.sink              in_i,
  input  wire logic            q_full_i,
  output logic                 push_o,
  output hsfd_pkg::frame_t     frame_o
);

  logic [2:0]  pos_q, pos_d, pos_eff;
  logic [7:0]  crc_q, crc_d, crc_eff, crc_next;
  logic [15:0] first_word_q, first_word_d;
  logic [15:0] second_word_q, second_word_d;
  logic        first_good_q, first_good_d;
  logic        kind_q;
  logic        accept;

  assign cfg_i.ready = 1'b1;
  assign in_i.ready  = !q_full_i;
  assign accept      = in_i.valid && in_i.ready;

  // A frame start drops any partial frame and makes this byte the first one.
  assign pos_eff  = in_i.frame_start ? 3'(hsfd_pkg::POS_FIRST_HI) : pos_q;
  assign crc_eff  = in_i.frame_start ? hsfd_pkg::CRC_INIT : crc_q;
  assign crc_next = hsfd_pkg::crc_feed(crc_eff, in_i.rx_byte);

  always_comb begin
    pos_d         = pos_eff + 3'd1;
    crc_d         = crc_next;
    first_word_d  = first_word_q;
    second_word_d = second_word_q;
    first_good_d  = first_good_q;
    push_o        = 1'b0;
    unique case (pos_eff)
      hsfd_pkg::POS_FIRST_HI: begin
        first_word_d[15:8] = in_i.rx_byte;
      end
      hsfd_pkg::POS_FIRST_LO: begin
        first_word_d[7:0] = in_i.rx_byte;
      end
      hsfd_pkg::POS_FIRST_CRC: begin
        first_good_d = (crc_eff == in_i.rx_byte);
        crc_d        = hsfd_pkg::CRC_INIT;
      end
      hsfd_pkg::POS_SECOND_HI: begin
        second_word_d[15:8] = in_i.rx_byte;
      end
      hsfd_pkg::POS_SECOND_LO: begin
        second_word_d[7:0] = in_i.rx_byte;
      end
      default: begin
        pos_d        = 3'(hsfd_pkg::POS_FIRST_HI);
        crc_d        = hsfd_pkg::CRC_INIT;
        first_good_d = 1'b0;
        push_o       = accept;
      end
    endcase
  end

  always_comb begin
    frame_o.serial_kind = kind_q;
    frame_o.crc_ok      = first_good_q && (crc_eff == in_i.rx_byte);
    frame_o.first_word  = first_word_q;
    frame_o.second_word = second_word_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q        <= 3'(hsfd_pkg::POS_FIRST_HI);
      crc_q        <= hsfd_pkg::CRC_INIT;
      first_good_q <= 1'b0;
      kind_q       <= 1'b0;
    end else begin
      if (accept) begin
        pos_q        <= pos_d;
        crc_q        <= crc_d;
        first_good_q <= first_good_d;
      end
      if (cfg_i.valid) begin
        kind_q <= cfg_i.frame_kind;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      first_word_q  <= first_word_d;
      second_word_q <= second_word_d;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/core/hsfd_queue.sv
// Short frame queue that decouples the front end from the conversion back end.
`default_nettype none

module hsfd_queue #(
  parameter int unsigned Depth = hsfd_pkg::QUEUE_DEPTH
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              push_i,
  input  wire hsfd_pkg::frame_t  frame_i,
  output logic                   full_o,
  input  wire logic              pop_i,
  output hsfd_pkg::queue_rd_t    rd_o
);

  localparam int unsigned PtrW = $clog2(Depth);
  localparam int unsigned CntW = $clog2(Depth + 1);

  hsfd_pkg::frame_t mem_q [Depth];
  logic [PtrW-1:0]  wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0]  count_q;

  function automatic logic [PtrW-1:0] next_ptr(input logic [PtrW-1:0] p);
    if (p == PtrW'(Depth - 1)) begin
      return '0;
    end
    return p + PtrW'(1);
  endfunction

  assign full_o     = (count_q == CntW'(Depth));
  assign rd_o.empty = (count_q == '0);
  assign rd_o.head  = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= next_ptr(wr_ptr_q);
      end
      if (pop_i) begin
        rd_ptr_q <= next_ptr(rd_ptr_q);
      end
      if (push_i && !pop_i) begin
        count_q <= count_q + CntW'(1);
      end else if (pop_i && !push_i) begin
        count_q <= count_q - CntW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= frame_i;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/core/hsfd_back.sv
// Back end: scales the raw words, sets the status and holds the result in an output register.
`default_nettype none

module hsfd_back (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire hsfd_pkg::queue_rd_t  rd_i,
  output logic                      pop_o,
  hsfd_out_if.source                out_o
);

  // Multiply stage.
  logic             s1_valid_q;
  hsfd_pkg::frame_t s1_frame_q;
  logic [30:0]      s1_t_prod_q;
  logic [30:0]      s1_h_prod_q;

  // Output register.
  logic               out_valid_q;
  logic [1:0]         status_q, status_d;
  logic [15:0]        raw_first_q, raw_second_q;
  logic signed [14:0] temp_q, temp_d;
  logic [13:0]        hum_q, hum_d;
  logic [31:0]        serial_q, serial_d;

  logic        out_load, s1_load;
  logic [14:0] t_quot, h_quot;
  logic [15:0] t_diff;
  logic signed [15:0] h_diff;

  assign out_load = !out_valid_q || out_o.ready;
  assign s1_load  = !s1_valid_q || out_load;
  assign pop_o    = !rd_i.empty && s1_load;

  assign t_quot = hsfd_pkg::div_full_scale(s1_t_prod_q);
  assign h_quot = hsfd_pkg::div_full_scale(s1_h_prod_q);
  assign t_diff = 16'(t_quot) - 16'(hsfd_pkg::TEMP_OFFSET);
  assign h_diff = $signed(16'(h_quot)) - $signed(16'(hsfd_pkg::HUM_OFFSET));

  always_comb begin
    status_d = hsfd_pkg::STATUS_OK;
    temp_d   = '0;
    hum_d    = '0;
    serial_d = '0;
    if (!s1_frame_q.crc_ok) begin
      status_d = hsfd_pkg::STATUS_CRC_ERR;
    end else if (s1_frame_q.serial_kind) begin
      serial_d = {s1_frame_q.first_word, s1_frame_q.second_word};
      if (serial_d == '0) begin
        status_d = hsfd_pkg::STATUS_ZERO_SERIAL;
      end
    end else begin
      temp_d = $signed(t_diff[14:0]);
      if (h_diff < 16'sd0) begin
        hum_d = '0;
      end else if (h_diff > $signed(16'(hsfd_pkg::HUM_MAX))) begin
        hum_d = 14'(hsfd_pkg::HUM_MAX);
      end else begin
        hum_d = h_diff[13:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (s1_load) begin
        s1_valid_q <= pop_o;
      end
      if (out_load) begin
        out_valid_q <= s1_valid_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      s1_frame_q  <= rd_i.head;
      s1_t_prod_q <= 31'(hsfd_pkg::TEMP_SCALE) * 31'(rd_i.head.first_word);
      s1_h_prod_q <= 31'(hsfd_pkg::HUM_SCALE) * 31'(rd_i.head.second_word);
    end
    if (out_load && s1_valid_q) begin
      status_q     <= status_d;
      raw_first_q  <= s1_frame_q.first_word;
      raw_second_q <= s1_frame_q.second_word;
      temp_q       <= temp_d;
      hum_q        <= hum_d;
      serial_q     <= serial_d;
    end
  end

  assign out_o.valid             = out_valid_q;
  assign out_o.status            = status_q;
  assign out_o.raw_first_word    = raw_first_q;
  assign out_o.raw_second_word   = raw_second_q;
  assign out_o.temperature_centi = temp_q;
  assign out_o.humidity_centi    = hum_q;
  assign out_o.serial_id         = serial_q;

endmodule

`default_nettype wire

FILE: rtl/core/humidity_sensor_frame_decoder_top.sv
// Top level of the sensor frame decoder: front end, frame queue and conversion back end.
// Throughput: one byte beat per cycle when not stalled; six beats yield one result beat.
// Each frame goes through the queue and the multiply stage into the output register.
// The front end stalls input beats only while the frame queue is full.
// Reset (rst_ni low, asynchronous) clears byte position, CRC, flags, queue and valids.
// After reset frame_kind is 0, selecting measurement frames.
`default_nettype none

module humidity_sensor_frame_decoder_top #(
  parameter int unsigned QueueDepth = hsfd_pkg::QUEUE_DEPTH
) (
  input  wire logic   clk_i,
  input  wire logic   rst_ni,
  hsfd_cfg_if.sink    cfg_i,
  hsfd_in_if.sink     in_i,
  hsfd_out_if.source  out_o
);

  // The front end pushes one frame record when the last CRC byte is accepted.
  logic                q_push;
  logic                q_full;
  logic                q_pop;
  hsfd_pkg::frame_t    q_frame;
  hsfd_pkg::queue_rd_t q_rd;

  // Byte assembly and CRC check. Configuration beats are always taken; the
  // frame kind is captured into each frame record as it leaves the front end.
  hsfd_front u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .cfg_i    (cfg_i),
    .in_i     (in_i),
    .q_full_i (q_full),
    .push_o   (q_push),
    .frame_o  (q_frame)
  );

  // Frame queue, so the front end keeps taking bytes while a result waits.
  hsfd_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .frame_i (q_frame),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .rd_o    (q_rd)
  );

  // Two-stage conversion: a multiply stage, then the division by full scale,
  // offset, clamp and status selection into the output register.
  hsfd_back u_back (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .rd_i   (q_rd),
    .pop_o  (q_pop),
    .out_o  (out_o)
  );

endmodule

`default_nettype wire
